[rtl/core/twr_pkg.sv]
// Package for the trajectory window replay block.
// Holds the point type, opcodes, status codes and register indexes.
// No dependencies.
package twr_pkg;

    localparam int STORE_DEPTH_DEF = 4096;
    localparam int WIN_MIN = 2;
    localparam int WIN_MAX = 64;
    localparam int FC_W = 7;
    localparam int TS_W = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 2'd1;

    typedef struct packed {
        logic signed [31:0] arc_length;
        logic signed [31:0] heading;
        logic signed [31:0] time_ms;
        logic signed [31:0] curvature_rate;
        logic signed [31:0] curvature;
        logic signed [31:0] accel;
        logic signed [31:0] speed;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } point_t;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -33'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[rtl/core/trajectory_window_replay.sv]
// Top level of the trajectory window replay block: sequencer, output
// register and configuration. Uses twr_pkg, twr_store and twr_dist.
//
// channel | handshake        | payload
// s       | s_tvalid/tready  | s_tdata points, s_tuser opcode
// m       | m_tvalid/tready  | m_tdata point, m_tlast, m_tuser status
// cfg     | cfg_we           | cfg_index, cfg_data
//
// A query reads every stored point through the single memory read port,
// one a cycle, then lets the distance pipeline drain before it reads the window.
// Reset empties the store; memories are not cleared. A stalled output
// holds the sequencer; the input is taken only while idle.
module trajectory_window_replay
    import twr_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // pos_x, pos_y, pos_z, speed, accel, curvature, curvature_rate,
    // time_ms, heading, arc_length
    input  logic [319:0]         s_tdata,
    // opcode
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_x, out_y, out_z, out_speed, out_accel, out_curvature,
    // out_curvature_rate, out_time, out_heading, out_arc_length
    output logic [319:0]         m_tdata,
    output logic                 m_tlast,
    // status
    output logic [1:0]           m_tuser,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TS_W-1:0]      cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SINGLE = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_T0RD   = 7'b0001000,
        S_T0WAIT = 7'b0010000,
        S_ERD    = 7'b0100000,
        S_EDATA  = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [FC_W-1:0]    fc_reg;
    logic [TS_W-1:0]    ts_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      scan_reg;
    logic [AW-1:0]      best_reg;
    logic [64:0]        best_d_reg;
    logic               best_set_reg;
    logic [FC_W-1:0]    n_reg;
    logic [FC_W-1:0]    fwd_reg;
    logic signed [31:0] qx_reg, qy_reg, t0_reg, pad_reg;
    logic [1:0]         pend_reg;
    logic               v1_reg;
    logic [AW-1:0]      idx1_reg;

    point_t             in_pt, rd_data, out_reg, ld_pt;
    logic               out_valid_reg, out_last_reg, out_free, ld, ld_last;
    logic [1:0]         out_status_reg, ld_status;
    logic               rd_en, wr_en, accept, scan_issue;
    logic [AW-1:0]      rd_addr;
    logic               dv, dbusy;
    logic [AW-1:0]      didx;
    logic [64:0]        ddist;
    logic [CW:0]        esum;
    logic               epad;
    logic [AW-1:0]      eaddr;
    logic signed [31:0] etime;
    logic [FC_W-1:0]    fwd_clip;

    assign in_pt    = point_t'(s_tdata);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign fwd_clip = (fc_reg < FC_W'(WIN_MIN)) ? FC_W'(WIN_MIN) :
                      (fc_reg > FC_W'(WIN_MAX)) ? FC_W'(WIN_MAX) : fc_reg;

    assign scan_issue = (state_reg == S_SCAN) && (scan_reg < count_reg);
    assign esum  = (CW+1)'(best_reg) + (CW+1)'(n_reg);
    assign epad  = esum >= (CW+1)'(count_reg);
    assign eaddr = epad ? AW'(count_reg - 1'b1) : esum[AW-1:0];
    assign etime = epad ? sat32(33'(pad_reg) + 33'(ts_reg))
                        : sat32(33'(rd_data.time_ms) - 33'(t0_reg));

    assign wr_en = accept && (s_tuser == OP_APPEND) && (count_reg != CW'(STORE_DEPTH));

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = eaddr;
        unique case (state_reg)
            S_SCAN:
            begin
                rd_en   = scan_issue;
                rd_addr = scan_reg[AW-1:0];
            end
            S_T0RD:
            begin
                rd_en   = 1'b1;
                rd_addr = best_reg;
            end
            S_ERD:   rd_en = 1'b1;
            default: rd_en = 1'b0;
        endcase
    end

    twr_store #(.STORE_DEPTH(STORE_DEPTH), .AW(AW)) u_store (
        .clk(clk), .wr_en(wr_en), .wr_addr(count_reg[AW-1:0]), .wr_data(in_pt),
        .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
    );

    twr_dist #(.AW(AW)) u_dist (
        .clk(clk), .rst_n(rst_n), .in_valid(v1_reg), .in_idx(idx1_reg),
        .px(rd_data.pos_x), .py(rd_data.pos_y), .qx(qx_reg), .qy(qy_reg),
        .out_valid(dv), .out_idx(didx), .out_dist(ddist), .busy(dbusy)
    );

    always_comb
    begin
        state_next = state_reg;
        ld        = 1'b0;
        ld_pt     = rd_data;
        ld_last   = 1'b1;
        ld_status = pend_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        OP_CLEAR, OP_APPEND: state_next = S_SINGLE;
                        OP_QUERY:  state_next = (count_reg < CW'(2)) ? S_SINGLE : S_SCAN;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_SINGLE:
            begin
                ld_pt = '0;
                if (out_free)
                begin
                    ld         = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (!scan_issue && !v1_reg && !dbusy)
                    state_next = S_T0RD;
            end
            S_T0RD:   state_next = S_T0WAIT;
            S_T0WAIT: state_next = S_ERD;
            S_ERD:    state_next = S_EDATA;
            S_EDATA:
            begin
                ld_pt.time_ms = etime;
                ld_last       = (n_reg == fwd_reg - 1'b1);
                ld_status     = ST_OK;
                if (out_free)
                begin
                    ld         = 1'b1;
                    state_next = ld_last ? S_IDLE : S_ERD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fc_reg        <= FC_W'(WIN_MAX);
            ts_reg        <= TS_W'(10);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            best_set_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= scan_issue;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FORWARD_COUNT: fc_reg <= cfg_data[FC_W-1:0];
                    REG_TIME_STEP:     ts_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (accept && s_tuser == OP_CLEAR)
                count_reg <= '0;
            if (wr_en)
                count_reg <= count_reg + 1'b1;
            if (ld)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (accept)
                best_set_reg <= 1'b0;
            else if (dv && (!best_set_reg || ddist < best_d_reg))
                best_set_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= scan_reg[AW-1:0];
        if (accept)
        begin
            qx_reg   <= in_pt.pos_x;
            qy_reg   <= in_pt.pos_y;
            scan_reg <= '0;
            n_reg    <= '0;
            fwd_reg  <= fwd_clip;
            case (s_tuser)
                OP_APPEND: pend_reg <= (count_reg == CW'(STORE_DEPTH)) ? ST_FULL : ST_OK;
                OP_QUERY:  pend_reg <= ST_SHORT;
                default:   pend_reg <= ST_OK;
            endcase
        end
        if (scan_issue)
            scan_reg <= scan_reg + 1'b1;
        if (dv && (!best_set_reg || ddist < best_d_reg))
        begin
            best_reg   <= didx;
            best_d_reg <= ddist;
        end
        if (state_reg == S_T0WAIT)
            t0_reg <= rd_data.time_ms;
        if (ld && state_reg == S_EDATA)
        begin
            pad_reg <= etime;
            n_reg   <= n_reg + 1'b1;
        end
        if (ld)
        begin
            out_reg        <= ld_pt;
            out_last_reg   <= ld_last;
            out_status_reg <= ld_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

`ifndef SYNTHESIS
    a_edata_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EDATA) |-> ($past(state_reg) == S_ERD || $past(state_reg) == S_EDATA))
        else $error("window output without a preceding store read");
    a_best_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERD) |-> (CW'(best_reg) < count_reg))
        else $error("matched point beyond the stored points");
    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EDATA) |-> (n_reg < fwd_reg))
        else $error("window emitted past its length");
`endif

endmodule

[rtl/core/twr_store.sv]
// Point store: five synchronous memories of 64-bit words, one write port
// and one read port with registered read data. Uses twr_pkg.
module twr_store
    import twr_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int AW = $clog2(STORE_DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  point_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output point_t        rd_data
);

    logic [63:0] position_mem   [STORE_DEPTH];
    logic [63:0] motion_mem     [STORE_DEPTH];
    logic [63:0] curvature_mem  [STORE_DEPTH];
    logic [63:0] time_head_mem  [STORE_DEPTH];
    logic [63:0] height_arc_mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            position_mem[wr_addr]   <= {wr_data.pos_x, wr_data.pos_y};
            motion_mem[wr_addr]     <= {wr_data.speed, wr_data.accel};
            curvature_mem[wr_addr]  <= {wr_data.curvature, wr_data.curvature_rate};
            time_head_mem[wr_addr]  <= {wr_data.time_ms, wr_data.heading};
            height_arc_mem[wr_addr] <= {wr_data.pos_z, wr_data.arc_length};
        end
        if (rd_en)
        begin
            {rd_data.pos_x, rd_data.pos_y}              <= position_mem[rd_addr];
            {rd_data.speed, rd_data.accel}              <= motion_mem[rd_addr];
            {rd_data.curvature, rd_data.curvature_rate} <= curvature_mem[rd_addr];
            {rd_data.time_ms, rd_data.heading}          <= time_head_mem[rd_addr];
            {rd_data.pos_z, rd_data.arc_length}         <= height_arc_mem[rd_addr];
        end
    end

endmodule

[rtl/core/twr_dist.sv]
// Squared distance pipeline: absolute differences, then registered squares,
// then the 65-bit sum. Carries the point index alongside. Uses twr_pkg.
module twr_dist
    import twr_pkg::*;
#(
    parameter int AW = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [AW-1:0]      in_idx,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] qx,
    input  logic signed [31:0] qy,
    output logic               out_valid,
    output logic [AW-1:0]      out_idx,
    output logic [64:0]        out_dist,
    output logic               busy
);

    logic              v2_reg, v3_reg;
    logic [AW-1:0]     idx2_reg, idx3_reg;
    logic [32:0]       dx_reg, dy_reg;
    logic [65:0]       sx_reg, sy_reg;
    logic signed [32:0] ddx, ddy;

    assign ddx = 33'(px) - 33'(qx);
    assign ddy = 33'(py) - 33'(qy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx2_reg <= in_idx;
        idx3_reg <= idx2_reg;
        dx_reg   <= ddx[32] ? 33'(-ddx) : 33'(ddx);
        dy_reg   <= ddy[32] ? 33'(-ddy) : 33'(ddy);
        sx_reg   <= dx_reg * dx_reg;
        sy_reg   <= dy_reg * dy_reg;
    end

    assign out_valid = v3_reg;
    assign out_idx   = idx3_reg;
    assign out_dist  = 65'(sx_reg) + 65'(sy_reg);
    assign busy      = v2_reg | v3_reg;

endmodule

[tb/sv/trajectory_window_replay_test.sv]
// Self-checking testbench for trajectory_window_replay: clear, append and nearest-point
// window queries, checked item by item against a predictor with its own point store.
// Depends on twr_pkg and the trajectory_window_replay RTL.
`timescale 1ns / 100ps

module trajectory_window_replay_test;
    import twr_pkg::*;

    localparam int DEPTH = 4096;
    localparam int CYCLE_LIMIT = 1500000;

    localparam logic [1:0]           OP_RESERVED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B  = 2'd3;

    typedef struct {
        point_t     pt;
        logic [1:0] op;
    } stim_t;

    typedef struct {
        point_t     pt;
        logic       last;
        logic [1:0] status;
    } window_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [319:0]         s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [319:0]         m_tdata;
    logic                 m_tlast;
    logic [1:0]           m_tuser;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TS_W-1:0]      cfg_data = '0;

    stim_t   pending_items[$];
    window_t window_expect[$];
    point_t  track[DEPTH];
    int      track_count;
    int      fwd_reg;
    int      step_reg;

    stim_t   cur_item;
    bit      cur_busy;
    int      burst_left;
    int      gap_left;
    bit      hold_req;
    bit      hold_done;
    int      hold_cnt;
    int      stall_left;
    int      cycles;
    int      errors;
    int      accepted_items;
    int      result_count;
    int      query_count;

    trajectory_window_replay u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic signed [31:0] clip32(input longint v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [65:0] sq_dist(input point_t p, input logic signed [31:0] qx,
                                            input logic signed [31:0] qy);
        longint     dx;
        longint     dy;
        logic [65:0] ax;
        logic [65:0] ay;
        dx = longint'(p.pos_x) - longint'(qx);
        dy = longint'(p.pos_y) - longint'(qy);
        ax = (dx < 0) ? 66'(-dx) : 66'(dx);
        ay = (dy < 0) ? 66'(-dy) : 66'(dy);
        return ax * ax + ay * ay;
    endfunction

    task automatic push_single(input logic [1:0] st);
        window_t w;
        w.pt = '0;
        w.last = 1'b1;
        w.status = st;
        window_expect.insert(window_expect.size(), w);
    endtask

    task automatic predict_window(input stim_t it);
        int          best;
        int          stop;
        int          win;
        int          n;
        longint      t0;
        longint      tl;
        logic [65:0] best_d;
        logic [65:0] d;
        window_t     w;
        case (it.op)
            OP_CLEAR:
            begin
                track_count = 0;
                push_single(ST_OK);
            end
            OP_APPEND:
            begin
                if (track_count >= DEPTH)
                    push_single(ST_FULL);
                else
                begin
                    track[track_count] = it.pt;
                    track_count++;
                    push_single(ST_OK);
                end
            end
            OP_QUERY:
            begin
                query_count++;
                if (track_count < 2)
                    push_single(ST_SHORT);
                else
                begin
                    win = (fwd_reg < WIN_MIN) ? WIN_MIN : (fwd_reg > WIN_MAX) ? WIN_MAX : fwd_reg;
                    best = 0;
                    best_d = sq_dist(track[0], it.pt.pos_x, it.pt.pos_y);
                    for (int i = 1; i < track_count; i++)
                    begin
                        d = sq_dist(track[i], it.pt.pos_x, it.pt.pos_y);
                        if (d < best_d)
                        begin
                            best_d = d;
                            best = i;
                        end
                    end
                    stop = (best + win >= track_count) ? track_count - 1 : best + win - 1;
                    t0 = longint'(track[best].time_ms);
                    n = 0;
                    for (int i = best; i <= stop; i++)
                    begin
                        w.pt = track[i];
                        w.pt.time_ms = clip32(longint'(track[i].time_ms) - t0);
                        w.last = 1'b0;
                        w.status = ST_OK;
                        window_expect.insert(window_expect.size(), w);
                        n++;
                    end
                    tl = longint'(w.pt.time_ms);
                    for (int k = 1; n < win; k++)
                    begin
                        w.pt = track[stop];
                        w.pt.time_ms = clip32(tl + longint'(k) * longint'(step_reg));
                        window_expect.insert(window_expect.size(), w);
                        n++;
                    end
                    window_expect[$].last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_window(cur_item);
                accepted_items++;
                cur_busy = 1'b0;
            end
            if (gap_left > 0)
                gap_left--;
            if (!cur_busy && gap_left == 0 && pending_items.size() > 0)
            begin
                cur_item = pending_items.pop_front();
                cur_busy = 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            s_tvalid <= cur_busy;
            s_tdata <= cur_item.pt;
            s_tuser <= cur_item.op;
        end
    end

    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            m_tready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= 600)
                hold_done = 1'b1;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 9) < 2)
        begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        window_t w;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycles);
            $display("Simulation FAILED");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            if (window_expect.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result item: data %h last %b status %0d",
                             m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                w = window_expect.pop_front();
                if (m_tdata !== w.pt || m_tlast !== w.last || m_tuser !== w.status)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: expected %h last %b status %0d, got %h last %b status %0d",
                                 w.pt, w.last, w.status, m_tdata, m_tlast, m_tuser);
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_word(input bit wide);
        logic signed [31:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'sh7FFF_FFFF;
            1: v = 32'sh8000_0000;
            default: v = wide ? $urandom : $signed($urandom_range(0, 2000)) - 1000;
        endcase
        return v;
    endfunction

    task automatic send(input logic [1:0] op, input point_t p);
        stim_t s;
        s.op = op;
        s.pt = p;
        pending_items.insert(pending_items.size(), s);
    endtask

    task automatic send_point(input logic [1:0] op, input bit wide);
        point_t p;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
        p.pos_x = rand_word(wide);
        p.pos_y = rand_word(wide);
        if ($urandom_range(0, 3) != 0)
            p.time_ms = $signed($urandom_range(0, 100000)) - 50000;
        send(op, p);
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || cur_busy || s_tvalid || window_expect.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[TS_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FORWARD_COUNT)
            fwd_reg = val & ((1 << FC_W) - 1);
        else if (idx == REG_TIME_STEP)
            step_reg = val & ((1 << TS_W) - 1);
    endtask

    initial
    begin
        point_t p;
        fwd_reg = 64;
        step_reg = 10;
        track_count = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: short store, ties, time saturation and padding.
        send_point(OP_QUERY, 1'b1);
        send_point(OP_APPEND, 1'b1);
        send_point(OP_QUERY, 1'b1);
        send_point(OP_RESERVED, 1'b1);
        send(OP_CLEAR, '0);
        p = '0;
        p.time_ms = 32'sh8000_0000;
        send(OP_APPEND, p);
        p = '1;
        p.pos_x = 32'sh7FFF_FFFF;
        p.pos_y = 32'sh8000_0000;
        p.time_ms = 32'sh7FFF_FFFF;
        send(OP_APPEND, p);
        send(OP_APPEND, p);
        p.pos_x = 32'sh8000_0000;
        p.pos_y = 32'sh7FFF_FFFF;
        send(OP_QUERY, '0);
        send(OP_QUERY, p);
        send_point(OP_QUERY, 1'b1);
        wait_idle();
        write_reg(REG_FORWARD_COUNT, 1);
        write_reg(REG_TIME_STEP, 1023);
        send(OP_QUERY, '0);
        send(OP_QUERY, p);
        wait_idle();
        write_reg(REG_FORWARD_COUNT, 127);
        write_reg(REG_TIME_STEP, 0);
        write_reg(REG_SPARE_A, 5);
        write_reg(REG_SPARE_B, 1);
        send(OP_QUERY, '0);
        send_point(OP_QUERY, 1'b0);
        wait_idle();

        // Build a longer store and scan it with short windows.
        write_reg(REG_FORWARD_COUNT, 2);
        write_reg(REG_TIME_STEP, 1000);
        send(OP_CLEAR, '0);
        for (int i = 0; i < 25; i++)
            send_point(OP_APPEND, 1'b1);
        for (int i = 0; i < 3; i++)
            send_point(OP_QUERY, 1'b1);
        send(OP_CLEAR, '0);
        wait_idle();

        // Random phases with different register settings.
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(REG_FORWARD_COUNT, (ph == 0) ? 64 : (ph == 1) ? 2 : $urandom_range(0, 127));
            write_reg(REG_TIME_STEP, (ph == 0) ? 1 : $urandom_range(0, 1023));
            send(OP_CLEAR, '0);
            for (int i = 0; i < 18; i++)
            begin
                case ($urandom_range(0, 19))
                    0: send_point(OP_CLEAR, 1'b1);
                    1: send_point(OP_RESERVED, 1'b1);
                    2, 3, 4, 5, 6, 7: send_point(OP_QUERY, $urandom_range(0, 1));
                    default: send_point(OP_APPEND, $urandom_range(0, 1));
                endcase
            end
            if (ph == 2)
                hold_req = 1'b1;
            wait_idle();
        end

        $display("Accepted %0d input items including %0d queries; checked %0d result items.",
                 accepted_items, query_count, result_count);
        $display("Covered empty, short, longer and random stores with several window settings.");
        if (errors == 0 && window_expect.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
